[rtl/spwm_pkg.sv]
// spwm_pkg: shared types, constants and the sine table for the sine-pwm modulator
// used by spwm_smul and spwm_modulator_pi_amplitude_core; no dependencies
`default_nettype none

package spwm_pkg;

  // field widths
  localparam int SETPOINT_W = 12;
  localparam int GAIN_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 12;
  localparam int PULSE_W    = 16;
  localparam int INDEX_W    = 8;
  localparam int LEVEL_W    = 13;
  localparam int ERR_W      = 13;
  localparam int DIFF_W     = 14;
  localparam int ACCUM_W    = 21;
  localparam int INC_W      = 32;
  localparam int MIX_W      = 20;

  // Q8 full scale: 4096 counts * 256
  localparam logic [ACCUM_W-1:0] LEVEL_FULL = ACCUM_W'(4096 * 256);
  // dc offset of the mix term: 128 * 4096
  localparam logic [ACCUM_W-1:0] MIX_OFFSET = ACCUM_W'(128 * 4096);
  localparam int SINE_MID = 128;

  // serial multiplier geometry
  localparam int MCAND_W  = 21;
  localparam int MPLIER_W = 16;
  localparam int PROD_W   = MCAND_W + MPLIER_W + 1;
  localparam int STEP_W   = $clog2(MPLIER_W);

  // sine table and phase counter
  localparam int ROM_SIZE         = 200;
  localparam int ROM_AW           = $clog2(ROM_SIZE);
  localparam int SINE_TABLE_DEPTH = 200;
  localparam int PHASE_W          = $clog2(SINE_TABLE_DEPTH);

  // phase to rom address: floor(phase * ROM_SIZE / SINE_TABLE_DEPTH) by reciprocal
  localparam int ADDR_SHIFT  = 21;
  localparam int ADDR_RECIP  = (ROM_SIZE * (2 ** ADDR_SHIFT) + SINE_TABLE_DEPTH - 1)
                               / SINE_TABLE_DEPTH;
  localparam int RECIP_W     = $clog2(ADDR_RECIP + 1);
  localparam int ADDR_PROD_W = PHASE_W + RECIP_W;

  localparam logic [7:0] SINE_ROM [ROM_SIZE] = '{
    8'd128, 8'd131, 8'd135, 8'd139, 8'd143, 8'd147, 8'd151, 8'd155,
    8'd159, 8'd163, 8'd167, 8'd171, 8'd174, 8'd178, 8'd182, 8'd185,
    8'd189, 8'd192, 8'd196, 8'd199, 8'd202, 8'd205, 8'd208, 8'd211,
    8'd214, 8'd217, 8'd220, 8'd223, 8'd225, 8'd228, 8'd230, 8'd233,
    8'd235, 8'd237, 8'd239, 8'd241, 8'd242, 8'd244, 8'd246, 8'd247,
    8'd248, 8'd249, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
    8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
    8'd252, 8'd251, 8'd251, 8'd249, 8'd248, 8'd247, 8'd246, 8'd244,
    8'd242, 8'd241, 8'd239, 8'd237, 8'd235, 8'd233, 8'd230, 8'd228,
    8'd225, 8'd223, 8'd220, 8'd217, 8'd214, 8'd211, 8'd208, 8'd205,
    8'd202, 8'd199, 8'd196, 8'd192, 8'd189, 8'd185, 8'd182, 8'd178,
    8'd174, 8'd171, 8'd167, 8'd163, 8'd159, 8'd155, 8'd151, 8'd147,
    8'd143, 8'd139, 8'd135, 8'd131, 8'd127, 8'd124, 8'd120, 8'd116,
    8'd112, 8'd108, 8'd104, 8'd100, 8'd96,  8'd92,  8'd88,  8'd84,
    8'd81,  8'd77,  8'd73,  8'd70,  8'd66,  8'd63,  8'd59,  8'd56,
    8'd53,  8'd50,  8'd47,  8'd44,  8'd41,  8'd38,  8'd35,  8'd32,
    8'd30,  8'd27,  8'd25,  8'd22,  8'd20,  8'd18,  8'd16,  8'd14,
    8'd13,  8'd11,  8'd9,   8'd8,   8'd7,   8'd6,   8'd4,   8'd4,
    8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd4,   8'd4,   8'd6,
    8'd7,   8'd8,   8'd9,   8'd11,  8'd13,  8'd14,  8'd16,  8'd18,
    8'd20,  8'd22,  8'd25,  8'd27,  8'd30,  8'd32,  8'd35,  8'd38,
    8'd41,  8'd44,  8'd47,  8'd50,  8'd53,  8'd56,  8'd59,  8'd63,
    8'd66,  8'd70,  8'd73,  8'd77,  8'd81,  8'd84,  8'd88,  8'd92,
    8'd96,  8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124
  };

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_KP       = 2'd1,
    CFG_KI       = 2'd2,
    CFG_PERIOD   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START_A,
    ST_WAIT_A,
    ST_START_B,
    ST_WAIT_B,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e                 opcode;
    logic [SAMPLE_W-1:0] adc_sample;
  } in_beat_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic [INDEX_W-1:0] sine_index;
    logic [LEVEL_W-1:0] drive_level;
  } out_beat_t;

  function automatic logic [ROM_AW-1:0] rom_addr(input logic [PHASE_W-1:0] phase);
    logic [ADDR_PROD_W-1:0] prod;
    logic [ADDR_PROD_W-1:0] quo;
    prod = ADDR_PROD_W'(phase) * ADDR_PROD_W'(ADDR_RECIP);
    quo  = prod >> ADDR_SHIFT;
    if (quo >= ADDR_PROD_W'(ROM_SIZE)) begin
      rom_addr = ROM_AW'(ROM_SIZE - 1);
    end else begin
      rom_addr = quo[ROM_AW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/spwm_modulator_pi_amplitude_core.sv]
// spwm_modulator_pi_amplitude_core: sine-pwm compare generator with incremental pi level loop
// depends on spwm_pkg and spwm_smul
`default_nettype none

// channel   direction  handshake               payload
// ------    ---------  ---------               -------
// in        input      in_valid_i / in_stall_o  in_data_i  (opcode, adc_sample)
// out       output     out_valid_o / out_stall_i out_data_o (pulse_width, sine_index, drive_level)
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// one item at a time: two 16-step bit-serial multiplies in spwm_smul run back to back
// (kp and ki terms for a sample, level*sine and period*mix for a tick), between the
// prep state that sets up the operands and the finish state that commits the result
// reset brings the configuration registers to their defaults, phase, error and level to zero
// a finished tick beat sits in the output register; a new item is taken while it waits,
// and a second tick holds in its commit cycle until the output register is free

module spwm_modulator_pi_amplitude_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire spwm_pkg::in_beat_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output spwm_pkg::out_beat_t                      out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire spwm_pkg::cfg_idx_e                  cfg_idx_i,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [spwm_pkg::SETPOINT_W-1:0] setpoint_q;
  logic [spwm_pkg::GAIN_W-1:0]     kp_q;
  logic [spwm_pkg::GAIN_W-1:0]     ki_q;
  logic [spwm_pkg::PERIOD_W-1:0]   period_q;

  // loop state
  spwm_pkg::state_e              state_q, state_d;
  logic [spwm_pkg::PHASE_W-1:0]  phase_q;
  logic signed [spwm_pkg::ERR_W-1:0] prev_err_q;
  logic [spwm_pkg::ACCUM_W-1:0]  accum_q;
  logic                          out_valid_q, out_valid_d;

  // per-item working registers
  spwm_pkg::op_e                     op_q;
  logic [spwm_pkg::SAMPLE_W-1:0]     sample_q;
  logic signed [spwm_pkg::ERR_W-1:0] err_q;
  logic signed [spwm_pkg::DIFF_W-1:0] diff_q;
  logic [spwm_pkg::ROM_AW-1:0]       addr_q;
  logic signed [spwm_pkg::INC_W-1:0] part_q;
  logic signed [spwm_pkg::INC_W-1:0] inc_q;
  logic [spwm_pkg::MIX_W-1:0]        mix_q;
  logic [spwm_pkg::PULSE_W-1:0]      pulse_q;
  spwm_pkg::out_beat_t               out_q;

  // serial multiplier hookup
  logic                                   mul_start;
  logic signed [spwm_pkg::MCAND_W-1:0]    mul_mcand;
  logic [spwm_pkg::MPLIER_W-1:0]          mul_mplier;
  logic                                   mul_done;
  logic signed [spwm_pkg::PROD_W-1:0]     mul_prod;

  // control decodes
  logic accept;
  logic out_free;
  logic out_load;
  logic level_commit;

  // datapath intermediates
  logic signed [spwm_pkg::ERR_W-1:0]    err_w;
  logic signed [spwm_pkg::DIFF_W-1:0]   diff_w;
  logic [7:0]                           sine_w;
  logic signed [spwm_pkg::MCAND_W-1:0]  sine_off_w;
  logic [spwm_pkg::ACCUM_W-1:0]         mix_sum_w;
  logic signed [spwm_pkg::INC_W:0]      level_sum_w;
  logic [spwm_pkg::ACCUM_W-1:0]         level_clamp_w;
  logic [spwm_pkg::PHASE_W-1:0]         phase_next_w;
  logic [spwm_pkg::LEVEL_W-1:0]         level_int_w;

  spwm_smul u_smul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (mul_mplier),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // error terms: setpoint minus reading, then the change since the last sample
  assign err_w  = spwm_pkg::ERR_W'({1'b0, setpoint_q}) - spwm_pkg::ERR_W'({1'b0, sample_q});
  assign diff_w = spwm_pkg::DIFF_W'(err_w) - spwm_pkg::DIFF_W'(prev_err_q);

  // sine sample centered on zero
  assign sine_w     = spwm_pkg::SINE_ROM[addr_q];
  assign sine_off_w = spwm_pkg::MCAND_W'({1'b0, sine_w}) - spwm_pkg::MCAND_W'(spwm_pkg::SINE_MID);

  // mix = 128*4096 + level*(sine-128), always positive and below 2^20
  assign mix_sum_w = mul_prod[spwm_pkg::ACCUM_W-1:0] + spwm_pkg::MIX_OFFSET;

  // saturate the updated level to 0..full scale
  always_comb begin
    level_sum_w = (spwm_pkg::INC_W + 1)'({1'b0, accum_q}) + (spwm_pkg::INC_W + 1)'(inc_q);
    if (level_sum_w[spwm_pkg::INC_W]) begin
      level_clamp_w = '0;
    end else if (level_sum_w > (spwm_pkg::INC_W + 1)'(spwm_pkg::LEVEL_FULL)) begin
      level_clamp_w = spwm_pkg::LEVEL_FULL;
    end else begin
      level_clamp_w = level_sum_w[spwm_pkg::ACCUM_W-1:0];
    end
  end

  assign level_int_w  = accum_q[spwm_pkg::ACCUM_W-1:8];
  assign phase_next_w = (phase_q == spwm_pkg::PHASE_W'(spwm_pkg::SINE_TABLE_DEPTH - 1))
                        ? '0 : phase_q + spwm_pkg::PHASE_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spwm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = spwm_pkg::ST_PREP;
      end
      spwm_pkg::ST_PREP:    state_d = spwm_pkg::ST_START_A;
      spwm_pkg::ST_START_A: state_d = spwm_pkg::ST_WAIT_A;
      spwm_pkg::ST_WAIT_A: begin
        if (mul_done) state_d = spwm_pkg::ST_START_B;
      end
      spwm_pkg::ST_START_B: state_d = spwm_pkg::ST_WAIT_B;
      spwm_pkg::ST_WAIT_B: begin
        if (mul_done) state_d = spwm_pkg::ST_FINISH;
      end
      spwm_pkg::ST_FINISH: begin
        if (op_q == spwm_pkg::OP_SAMPLE || out_free) state_d = spwm_pkg::ST_IDLE;
      end
      default: state_d = spwm_pkg::ST_IDLE;
    endcase
  end

  // state outputs and multiplier operand select
  always_comb begin
    in_stall_o   = 1'b1;
    mul_start    = 1'b0;
    mul_mcand    = '0;
    mul_mplier   = '0;
    out_load     = 1'b0;
    level_commit = 1'b0;
    case (state_q)
      spwm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      spwm_pkg::ST_START_A: begin
        mul_start = 1'b1;
        if (op_q == spwm_pkg::OP_SAMPLE) begin
          // kp * (error - last error)
          mul_mcand  = spwm_pkg::MCAND_W'(diff_q);
          mul_mplier = kp_q;
        end else begin
          // (sine - 128) * level
          mul_mcand  = sine_off_w;
          mul_mplier = spwm_pkg::MPLIER_W'(level_int_w);
        end
      end
      spwm_pkg::ST_START_B: begin
        mul_start = 1'b1;
        if (op_q == spwm_pkg::OP_SAMPLE) begin
          // ki * error
          mul_mcand  = spwm_pkg::MCAND_W'(err_q);
          mul_mplier = ki_q;
        end else begin
          // period * mix
          mul_mcand  = spwm_pkg::MCAND_W'({1'b0, mix_q});
          mul_mplier = period_q;
        end
      end
      spwm_pkg::ST_FINISH: begin
        level_commit = (op_q == spwm_pkg::OP_SAMPLE);
        out_load     = (op_q == spwm_pkg::OP_TICK) && out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // output register: set on a tick commit, cleared when the beat is taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spwm_pkg::ST_IDLE;
      setpoint_q  <= spwm_pkg::SETPOINT_W'(496);
      kp_q        <= spwm_pkg::GAIN_W'(6400);
      ki_q        <= '0;
      period_q    <= spwm_pkg::PERIOD_W'(1600);
      phase_q     <= '0;
      prev_err_q  <= '0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spwm_pkg::CFG_SETPOINT: setpoint_q <= cfg_data_i[spwm_pkg::SETPOINT_W-1:0];
          spwm_pkg::CFG_KP:       kp_q       <= cfg_data_i[spwm_pkg::GAIN_W-1:0];
          spwm_pkg::CFG_KI:       ki_q       <= cfg_data_i[spwm_pkg::GAIN_W-1:0];
          spwm_pkg::CFG_PERIOD:   period_q   <= cfg_data_i[spwm_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (level_commit) begin
        accum_q    <= level_clamp_w;
        prev_err_q <= err_q;
      end
      if (out_load) begin
        phase_q <= phase_next_w;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_data_i.opcode;
      sample_q <= in_data_i.adc_sample;
    end
    if (state_q == spwm_pkg::ST_PREP) begin
      err_q  <= err_w;
      diff_q <= diff_w;
      addr_q <= spwm_pkg::rom_addr(phase_q);
    end
    if (state_q == spwm_pkg::ST_WAIT_A && mul_done) begin
      part_q <= mul_prod[spwm_pkg::INC_W-1:0];
      mix_q  <= mix_sum_w[spwm_pkg::MIX_W-1:0];
    end
    if (state_q == spwm_pkg::ST_WAIT_B && mul_done) begin
      inc_q   <= part_q + mul_prod[spwm_pkg::INC_W-1:0];
      pulse_q <= mul_prod[spwm_pkg::MIX_W+spwm_pkg::PULSE_W-1:spwm_pkg::MIX_W];
    end
    if (out_load) begin
      out_q.pulse_width <= pulse_q;
      out_q.sine_index  <= spwm_pkg::INDEX_W'(phase_q);
      out_q.drive_level <= level_int_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/spwm_smul.sv]
// spwm_smul: bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
// one multiplier bit per cycle; depends on spwm_pkg
`default_nettype none

module spwm_smul (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [spwm_pkg::MCAND_W-1:0] mcand_i,
  input  wire logic        [spwm_pkg::MPLIER_W-1:0] mplier_i,
  output logic                                     done_o,
  output logic signed [spwm_pkg::PROD_W-1:0]       product_o
);

  localparam int HI_W = spwm_pkg::MCAND_W + 1;

  logic                                busy_q;
  logic                                done_q;
  logic [spwm_pkg::STEP_W-1:0]         step_q;
  logic signed [spwm_pkg::MCAND_W-1:0] mcand_q;
  logic signed [HI_W-1:0]              hi_q, hi_d;
  logic [spwm_pkg::MPLIER_W-1:0]       lo_q, lo_d;
  logic signed [HI_W-1:0]              sum;
  logic                                last_step;

  assign last_step = (step_q == spwm_pkg::STEP_W'(spwm_pkg::MPLIER_W - 1));

  // add on the lsb, then shift the whole partial product right by one
  always_comb begin
    sum  = hi_q + (lo_q[0] ? {mcand_q[spwm_pkg::MCAND_W-1], mcand_q} : HI_W'(0));
    hi_d = {sum[HI_W-1], sum[HI_W-1:1]};
    lo_d = {sum[0], lo_q[spwm_pkg::MPLIER_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + spwm_pkg::STEP_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

`default_nettype wire
